/* sv/ntr_pkg.sv */
// Package for the task runtime top-N ranker.
// Holds payload structs, state codes, register indexes and default sizes.
// No dependencies.
`default_nettype none
package ntr_pkg;

    localparam int MAX_TASKS_DEF    = 64;
    localparam int MAX_TOP_DEF      = 16;
    localparam int COUNTER_BITS_DEF = 32;

    localparam logic [7:0] CFG_TOP_N   = 8'd0;
    localparam logic [7:0] CFG_MIN_PCT = 8'd1;

    localparam logic [4:0] TOP_N_RST   = 5'd10;
    localparam logic [6:0] MIN_PCT_RST = 7'd1;
    localparam logic [6:0] PCT_FULL    = 7'd100;

    typedef struct packed {
        logic [31:0] task_id;
        logic [31:0] runtime_count;
        logic [31:0] interval_us;
        logic        last_entry;
    } t_in;

    typedef struct packed {
        logic [3:0]  rank;
        logic [31:0] ranked_task_id;
        logic [6:0]  percent;
        logic        last_result;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_D_LOAD,
        S_D_SCAN,
        S_K_INIT,
        S_K_SCAN,
        S_K_PICK,
        S_K_DIV,
        S_K_PUSH,
        S_K_FLUSH
    } t_state;

endpackage
`default_nettype wire

/* sv/task_runtime_top_n_ranker.sv */
// Task runtime top-N ranker. Non-final entries are taken without a stall. A final
// entry with a nonzero interval and an existing baseline runs a baseline match,
// then per rank a scan, a pick step, the percent divider and a push step. One
// snapshot is worked on at a time; results leave through an output register.
// Synchronous active-low reset clears counts, flags and config to defaults.
`default_nettype none
module task_runtime_top_n_ranker #(
    parameter int MAX_TASKS    = ntr_pkg::MAX_TASKS_DEF,
    parameter int MAX_TOP      = ntr_pkg::MAX_TOP_DEF,
    parameter int COUNTER_BITS = ntr_pkg::COUNTER_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire ntr_pkg::t_in i_data,
    output logic              o_stall,
    output logic              o_valid,
    output ntr_pkg::t_out     o_data,
    input  wire logic         i_stall,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    logic [4:0] r_top_n;
    logic [6:0] r_min_pct;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_n   <= ntr_pkg::TOP_N_RST;
            r_min_pct <= ntr_pkg::MIN_PCT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == ntr_pkg::CFG_TOP_N)
                r_top_n <= i_cfg_data[4:0];
            else if (i_cfg_index == ntr_pkg::CFG_MIN_PCT)
                r_min_pct <= i_cfg_data[6:0];
        end
    end

    ntr_core #(
        .MAX_TASKS    (MAX_TASKS),
        .MAX_TOP      (MAX_TOP),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall),
        .i_top_n   (r_top_n),
        .i_min_pct (r_min_pct)
    );
endmodule
`default_nettype wire

/* sv/ntr_pct.sv */
// Percent unit: delta * 100 / interval, saturated at 100.
// Restoring division, one quotient bit per cycle; uses ntr_pkg.
`default_nettype none
module ntr_pct #(
    parameter int COUNTER_BITS = ntr_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [COUNTER_BITS-1:0] i_delta,
    input  wire logic [31:0]             i_interval,
    output logic                         o_done,
    output logic [6:0]                   o_pct
);
    localparam int BW = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;
    localparam int W  = BW + 7;

    logic         r_busy;
    logic         r_done;
    logic [2:0]   r_step;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_div;
    logic [6:0]   r_q;
    logic [W-1:0] d_ext;
    logic [W-1:0] iv_ext;
    logic [W-1:0] sh;

    assign d_ext  = W'(i_delta);
    assign iv_ext = W'(i_interval);
    assign sh     = r_div << r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (d_ext >= iv_ext) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_step == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (d_ext >= iv_ext) begin
                r_q <= ntr_pkg::PCT_FULL;
            end else begin
                r_q    <= '0;
                r_rem  <= (d_ext << 6) + (d_ext << 5) + (d_ext << 2);
                r_div  <= iv_ext;
                r_step <= 3'd6;
            end
        end else if (r_busy) begin
            if (r_rem >= sh) begin
                r_rem <= r_rem - sh;
                r_q[r_step] <= 1'b1;
            end
            r_step <= r_step - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_pct  = r_q;
endmodule
`default_nettype wire

/* sv/ntr_core.sv */
// Ranker core: task memory (two banks), delta memory, picked flags, sequencer.
// Uses ntr_pkg and ntr_pct.
`default_nettype none
module ntr_core #(
    parameter int MAX_TASKS    = ntr_pkg::MAX_TASKS_DEF,
    parameter int MAX_TOP      = ntr_pkg::MAX_TOP_DEF,
    parameter int COUNTER_BITS = ntr_pkg::COUNTER_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire ntr_pkg::t_in i_data,
    output logic              o_stall,
    output logic              o_valid,
    output ntr_pkg::t_out     o_data,
    input  wire logic         i_stall,
    input  wire logic [4:0]   i_top_n,
    input  wire logic [6:0]   i_min_pct
);
    localparam int CB    = COUNTER_BITS;
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int AW    = $clog2(2 * MAX_TASKS);
    localparam int RK_W  = $clog2(MAX_TOP + 1);
    localparam int LW    = (RK_W > 5) ? RK_W : 5;
    localparam int EW    = 32 + CB;

    ntr_pkg::t_state r_state, n_state;

    logic [EW-1:0] m_task [0:2*MAX_TASKS-1];
    logic [CB-1:0] m_delta [0:MAX_TASKS-1];
    logic [MAX_TASKS-1:0] r_picked;

    logic [EW-1:0] r_rd_a, r_rd_b;
    logic [CB-1:0] r_rd_d;

    logic             r_bank;
    logic [CNT_W-1:0] r_snap_cnt, r_base_cnt, r_n, r_i, r_j;
    logic [31:0]      r_interval;
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;
    logic             r_best_v;
    logic [CB-1:0]    r_best_d;
    logic [31:0]      r_best_id;
    logic [IDX_W-1:0] r_best_idx;
    logic [RK_W-1:0]  r_rank;
    logic [6:0]       r_pct;
    logic             r_pend_v;
    ntr_pkg::t_out    r_pend;
    logic             r_out_v;
    ntr_pkg::t_out    r_out;

    logic             acc, room, out_free, can_push;
    logic [AW-1:0]    addr_a, addr_b, addr_w;
    logic             task_we, delta_we, div_start, div_done;
    logic [EW-1:0]    wd_task;
    logic [CB-1:0]    rt_c, delta_w;
    logic [CB+31:0]   rt_ext;
    logic [6:0]       div_pct;
    logic             issue_d, issue_k, match, resolve, last_i, scan_done;
    logic             better, fail, rank_end;
    logic [LW-1:0]    top_ext, lim;
    logic [RK_W+3:0]  rk_ext;
    logic [CNT_W-1:0] n_last;
    logic             out_load, out_last;
    ntr_pkg::t_out    pend_fin;

    function automatic logic [AW-1:0] taddr(input logic bank, input logic [IDX_W-1:0] idx);
        taddr = bank ? (AW'(MAX_TASKS) + AW'(idx)) : AW'(idx);
    endfunction

    assign acc      = (r_state == ntr_pkg::S_IDLE) && i_valid;
    assign room     = r_snap_cnt < CNT_W'(MAX_TASKS);
    assign n_last   = r_snap_cnt + (room ? CNT_W'(1) : CNT_W'(0));
    assign rt_ext   = {{CB{1'b0}}, i_data.runtime_count};
    assign rt_c     = rt_ext[CB-1:0];
    assign wd_task  = {i_data.task_id, rt_c};
    assign out_free = !r_out_v || !i_stall;
    assign can_push = !r_pend_v || out_free;

    assign issue_d   = r_j < r_base_cnt;
    assign match     = r_pv && (r_rd_a[EW-1:CB] == r_rd_b[EW-1:CB]);
    assign resolve   = match || (!r_pv && !issue_d);
    assign delta_w   = match ? (r_rd_a[CB-1:0] - r_rd_b[CB-1:0]) : '0;
    assign last_i    = r_i == (r_n - CNT_W'(1));
    assign issue_k   = r_i < r_n;
    assign scan_done = !r_pv && !issue_k;
    assign better    = r_pv && !r_picked[r_pidx] && (!r_best_v || r_rd_d > r_best_d);

    assign top_ext  = LW'(i_top_n);
    assign lim      = (top_ext > LW'(MAX_TOP)) ? LW'(MAX_TOP) : top_ext;
    assign rank_end = (LW'(r_rank) + LW'(1)) == lim;
    assign fail     = (r_rank != '0) && (r_pct < i_min_pct);
    assign rk_ext   = {4'b0, r_rank};

    // the held result is not the last when another one is pushed behind it
    assign out_load = ((r_state == ntr_pkg::S_K_PUSH) && !fail && can_push && r_pend_v)
                   || ((r_state == ntr_pkg::S_K_FLUSH) && r_pend_v && out_free);
    assign out_last = r_state == ntr_pkg::S_K_FLUSH;

    always_comb begin
        pend_fin             = r_pend;
        pend_fin.last_result = 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ntr_pkg::S_IDLE: begin
                if (acc && i_data.last_entry && i_data.interval_us != '0 && r_base_cnt != '0)
                    n_state = ntr_pkg::S_D_LOAD;
            end
            ntr_pkg::S_D_LOAD: n_state = ntr_pkg::S_D_SCAN;
            ntr_pkg::S_D_SCAN: begin
                if (resolve) begin
                    if (!last_i)
                        n_state = ntr_pkg::S_D_LOAD;
                    else if (lim == '0)
                        n_state = ntr_pkg::S_IDLE;
                    else
                        n_state = ntr_pkg::S_K_INIT;
                end
            end
            ntr_pkg::S_K_INIT: n_state = ntr_pkg::S_K_SCAN;
            ntr_pkg::S_K_SCAN: begin
                if (scan_done) n_state = ntr_pkg::S_K_PICK;
            end
            ntr_pkg::S_K_PICK: begin
                n_state = r_best_v ? ntr_pkg::S_K_DIV : ntr_pkg::S_K_FLUSH;
            end
            ntr_pkg::S_K_DIV: begin
                if (div_done) n_state = ntr_pkg::S_K_PUSH;
            end
            ntr_pkg::S_K_PUSH: begin
                if (fail)
                    n_state = ntr_pkg::S_K_FLUSH;
                else if (can_push)
                    n_state = rank_end ? ntr_pkg::S_K_FLUSH : ntr_pkg::S_K_INIT;
            end
            ntr_pkg::S_K_FLUSH: begin
                if (!r_pend_v || out_free) n_state = ntr_pkg::S_IDLE;
            end
            default: n_state = ntr_pkg::S_IDLE;
        endcase
    end

    // memory ports and unit strobes
    always_comb begin
        o_stall   = r_state != ntr_pkg::S_IDLE;
        task_we   = acc && room;
        addr_w    = taddr(!r_bank, r_snap_cnt[IDX_W-1:0]);
        addr_b    = taddr(r_bank, r_j[IDX_W-1:0]);
        delta_we  = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            ntr_pkg::S_D_LOAD, ntr_pkg::S_D_SCAN: begin
                addr_a   = taddr(!r_bank, r_i[IDX_W-1:0]);
                delta_we = (r_state == ntr_pkg::S_D_SCAN) && resolve;
            end
            default: begin
                addr_a    = taddr(r_bank, r_i[IDX_W-1:0]);
                div_start = (r_state == ntr_pkg::S_K_PICK) && r_best_v;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (task_we) m_task[addr_w] <= wd_task;
        r_rd_a <= m_task[addr_a];
        r_rd_b <= m_task[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (delta_we) m_delta[r_i[IDX_W-1:0]] <= delta_w;
        r_rd_d <= m_delta[r_i[IDX_W-1:0]];
    end

    ntr_pct #(
        .COUNTER_BITS(CB)
    ) u_pct (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_delta    (r_best_d),
        .i_interval (r_interval),
        .o_done     (div_done),
        .o_pct      (div_pct)
    );

    // output register: load from the held result, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_load) begin
            r_out_v <= 1'b1;
            r_out   <= out_last ? pend_fin : r_pend;
        end else if (r_out_v && !i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ntr_pkg::S_IDLE;
            r_bank     <= 1'b0;
            r_snap_cnt <= '0;
            r_base_cnt <= '0;
            r_picked   <= '0;
            r_pv       <= 1'b0;
            r_best_v   <= 1'b0;
            r_pend_v   <= 1'b0;
            r_rank     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ntr_pkg::S_IDLE: begin
                    if (acc) begin
                        r_snap_cnt <= i_data.last_entry ? '0 : n_last;
                        if (i_data.last_entry) begin
                            r_picked   <= '0;
                            r_n        <= n_last;
                            r_interval <= i_data.interval_us;
                            r_i        <= '0;
                            r_rank     <= '0;
                            // first usable snapshot only becomes the baseline
                            if (i_data.interval_us != '0 && r_base_cnt == '0) begin
                                r_bank     <= !r_bank;
                                r_base_cnt <= n_last;
                            end
                        end
                    end
                end
                ntr_pkg::S_D_LOAD: begin
                    r_j  <= '0;
                    r_pv <= 1'b0;
                end
                ntr_pkg::S_D_SCAN: begin
                    r_pv <= issue_d;
                    if (issue_d) r_j <= r_j + CNT_W'(1);
                    if (resolve) begin
                        if (last_i) begin
                            r_bank     <= !r_bank;
                            r_base_cnt <= r_n;
                            r_i        <= '0;
                        end else begin
                            r_i <= r_i + CNT_W'(1);
                        end
                    end
                end
                ntr_pkg::S_K_INIT: begin
                    r_i      <= '0;
                    r_pv     <= 1'b0;
                    r_best_v <= 1'b0;
                end
                ntr_pkg::S_K_SCAN: begin
                    r_pv   <= issue_k;
                    r_pidx <= r_i[IDX_W-1:0];
                    if (issue_k) r_i <= r_i + CNT_W'(1);
                    if (better) begin
                        r_best_v   <= 1'b1;
                        r_best_d   <= r_rd_d;
                        r_best_id  <= r_rd_a[EW-1:CB];
                        r_best_idx <= r_pidx;
                    end
                end
                ntr_pkg::S_K_PICK: begin
                    if (r_best_v) r_picked[r_best_idx] <= 1'b1;
                end
                ntr_pkg::S_K_DIV: begin
                    if (div_done) r_pct <= div_pct;
                end
                ntr_pkg::S_K_PUSH: begin
                    if (!fail && can_push) begin
                        r_pend_v              <= 1'b1;
                        r_pend.rank           <= rk_ext[3:0];
                        r_pend.ranked_task_id <= r_best_id;
                        r_pend.percent        <= r_pct;
                        r_pend.last_result    <= 1'b0;
                        r_rank                <= r_rank + RK_W'(1);
                    end
                end
                ntr_pkg::S_K_FLUSH: begin
                    if (r_pend_v && out_free) r_pend_v <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;
endmodule
`default_nettype wire

/* sv/ntr_checker.sv */
// Port-level checks for the task runtime top-N ranker, bound to the top level.
// Uses ntr_pkg.
`default_nettype none
module ntr_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_valid,
    input wire ntr_pkg::t_in  i_data,
    input wire logic          o_stall,
    input wire logic          o_valid,
    input wire ntr_pkg::t_out o_data,
    input wire logic          i_stall
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.percent <= ntr_pkg::PCT_FULL)
        else $error("percent above 100");

    a_mid_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_data.last_entry |=> !o_stall)
        else $error("stall after a non-final entry");

    a_zero_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.last_entry && i_data.interval_us == 32'd0
        |=> !o_stall)
        else $error("stall after a zero-interval snapshot");
endmodule

bind task_runtime_top_n_ranker ntr_checker u_chk (.*);
`default_nettype wire

/* sim/tb.sv */
// Testbench for task_runtime_top_n_ranker: drives task snapshots, predicts the ranked
// output in a model of its own and checks every output transaction.
// Depends on ntr_pkg and the ranker RTL.
`timescale 1ns / 100ps
module tb;
    localparam int TASKS     = 64;
    localparam int TOP_MAX   = 16;
    localparam int HOLD_LEN  = 3000;
    localparam int DRAIN_GAP = 6000;
    localparam int WD_LIMIT  = 80000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    ntr_pkg::t_in  i_data = '0;
    logic          o_stall;
    logic          o_valid;
    ntr_pkg::t_out o_data;
    logic          i_stall = 1'b1;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [7:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_data = '0;

    task_runtime_top_n_ranker DUT (.*);

    always #5 i_clk = ~i_clk;

    // ranking model state
    logic [31:0]   base_ids [TASKS];
    logic [31:0]   base_rt [TASKS];
    int            base_cnt;
    logic [31:0]   snap_ids [TASKS];
    logic [31:0]   snap_rt [TASKS];
    int            snap_cnt;
    logic [4:0]    top_n_reg;
    logic [6:0]    min_pct_reg;
    ntr_pkg::t_out ranked_q [$];

    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_go = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    // previous snapshot as sent, used to shape realistic deltas
    logic [31:0] prev_ids [$];
    logic [31:0] prev_rt [$];

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [6:0] busy_percent(logic [31:0] delta, logic [31:0] interval);
        logic [63:0] prod;
        if (delta >= interval) return ntr_pkg::PCT_FULL;
        prod = {32'd0, delta} * 64'd100;
        return 7'(prod / {32'd0, interval});
    endfunction

    task automatic rank_snapshot(ntr_pkg::t_in x);
        logic [31:0]   deltas [TASKS];
        logic          picked [TASKS];
        logic [31:0]   interval;
        int            n, limit, best, cnt;
        logic [6:0]    pct;
        ntr_pkg::t_out res;
        if (snap_cnt < TASKS) begin
            snap_ids[snap_cnt] = x.task_id;
            snap_rt[snap_cnt] = x.runtime_count;
            snap_cnt++;
        end
        if (!x.last_entry) return;
        interval = x.interval_us;
        n = snap_cnt;
        snap_cnt = 0;
        if (n == 0 || interval == 0) return;
        for (int i = 0; i < n; i++) begin
            deltas[i] = '0;
            picked[i] = 1'b0;
            for (int j = 0; j < base_cnt; j++) begin
                if (base_ids[j] == snap_ids[i]) begin
                    deltas[i] = snap_rt[i] - base_rt[j];
                    break;
                end
            end
        end
        // first snapshot only seeds the baseline
        if (base_cnt == 0) begin
            for (int i = 0; i < n; i++) begin
                base_ids[i] = snap_ids[i];
                base_rt[i] = snap_rt[i];
            end
            base_cnt = n;
            return;
        end
        for (int i = 0; i < n; i++) begin
            base_ids[i] = snap_ids[i];
            base_rt[i] = snap_rt[i];
        end
        base_cnt = n;
        limit = (top_n_reg > TOP_MAX) ? TOP_MAX : int'(top_n_reg);
        cnt = 0;
        for (int r = 0; r < limit; r++) begin
            best = -1;
            for (int i = 0; i < n; i++)
                if (!picked[i] && (best < 0 || deltas[i] > deltas[best])) best = i;
            if (best < 0) break;
            picked[best] = 1'b1;
            pct = busy_percent(deltas[best], interval);
            if (r > 0 && pct < min_pct_reg) break;
            res.rank = 4'(r);
            res.ranked_task_id = snap_ids[best];
            res.percent = pct;
            res.last_result = 1'b0;
            ranked_q.push_back(res);
            cnt++;
        end
        if (cnt > 0) ranked_q[ranked_q.size() - 1].last_result = 1'b1;
    endtask

    // receiver stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_LEN;
            i_stall <= 1'b1;
        end else begin
            if (hold_left != 0) hold_left <= hold_left - 1;
            i_stall <= (hold_left > 1) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // check each output transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (ranked_q.size() == 0) begin
                report_mismatch("unexpected result task", o_data.ranked_task_id, 32'd0);
            end else begin
                ntr_pkg::t_out want;
                want = ranked_q.pop_front();
                if (o_data.rank !== want.rank)
                    report_mismatch("rank", o_data.rank, want.rank);
                if (o_data.ranked_task_id !== want.ranked_task_id)
                    report_mismatch("ranked_task_id", o_data.ranked_task_id, want.ranked_task_id);
                if (o_data.percent !== want.percent)
                    report_mismatch("percent", o_data.percent, want.percent);
                if (o_data.last_result !== want.last_result)
                    report_mismatch("last_result", o_data.last_result, want.last_result);
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
                || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_entry(logic [31:0] id, logic [31:0] rt, logic [31:0] interval,
                              logic last);
        ntr_pkg::t_in x;
        x.task_id = id;
        x.runtime_count = rt;
        x.interval_us = interval;
        x.last_entry = last;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        rank_snapshot(x);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        i_valid <= 1'b0;
        while (ranked_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == ntr_pkg::CFG_TOP_N) top_n_reg = val[4:0];
        else if (idx == ntr_pkg::CFG_MIN_PCT) min_pct_reg = val[6:0];
    endtask

    // one snapshot whose tasks mostly carry over from the previous one
    task automatic send_snapshot(int n, logic [31:0] interval, int max_delta);
        logic [31:0] ids [$];
        logic [31:0] rts [$];
        logic [31:0] next_id;
        next_id = (prev_ids.size() != 0) ? prev_ids[prev_ids.size() - 1] + 1 : $urandom();
        for (int i = 0; i < n; i++) begin
            if (i < prev_ids.size() && $urandom_range(99) < 85) begin
                ids.push_back(prev_ids[i]);
                rts.push_back(prev_rt[i] + $urandom_range(max_delta));
            end else begin
                ids.push_back(next_id);
                rts.push_back($urandom());
                next_id = next_id + $urandom_range(1, 50);
            end
        end
        for (int i = 0; i < n; i++)
            send_entry(ids[i], rts[i], (i == n - 1) ? interval : $urandom(), i == n - 1);
        if (interval != 0) begin
            prev_ids = ids;
            prev_rt = rts;
        end
    endtask

    task automatic test_baseline_seed;
        // zero interval before any baseline, then a seeding snapshot
        send_entry(32'd5, 32'd100, 32'd0, 1'b1);
        send_entry(32'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
        send_entry(32'd7, 32'd0, 32'd0, 1'b0);
        send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1000, 1'b1);
    endtask

    task automatic test_extremes;
        // counter wrap, unknown id, tie, saturation, tiny interval
        send_entry(32'd0, 32'h0000_0010, 32'hFFFF_FFFF, 1'b0);
        send_entry(32'd7, 32'd50, 32'd0, 1'b0);
        send_entry(32'd9, 32'd77, 32'd0, 1'b0);
        send_entry(32'hFFFF_FFFF, 32'd49, 32'd1000, 1'b1);
        send_entry(32'd0, 32'h0000_0030, 32'd0, 1'b0);
        send_entry(32'd7, 32'd82, 32'd0, 1'b0);
        send_entry(32'd9, 32'd109, 32'd0, 1'b0);
        send_entry(32'hFFFF_FFFF, 32'd49, 32'd0, 1'b1);
        send_entry(32'd0, 32'h0000_0031, 32'd1, 1'b1);
        send_entry(32'd0, 32'h8000_0031, 32'hFFFF_FFFF, 1'b1);
        prev_ids = {32'd0};
        prev_rt = {32'h8000_0031};
    endtask

    task automatic test_registers;
        write_reg(ntr_pkg::CFG_TOP_N, 32'hFFFF_FFE0);
        send_snapshot(3, 32'd100, 60);
        write_reg(ntr_pkg::CFG_TOP_N, 32'd31);
        write_reg(ntr_pkg::CFG_MIN_PCT, 32'd0);
        send_snapshot(20, 32'd200, 100);
        write_reg(ntr_pkg::CFG_MIN_PCT, 32'd127);
        send_snapshot(5, 32'd100, 150);
        write_reg(ntr_pkg::CFG_TOP_N, 32'd1);
        write_reg(ntr_pkg::CFG_MIN_PCT, 32'd100);
        send_snapshot(4, 32'd100, 200);
    endtask

    task automatic test_overflow;
        write_reg(ntr_pkg::CFG_TOP_N, 32'd16);
        write_reg(ntr_pkg::CFG_MIN_PCT, 32'd0);
        send_snapshot(70, 32'd5000, 400);
        if (prev_ids.size() > TASKS) begin
            prev_ids = prev_ids[0:TASKS-1];
            prev_rt = prev_rt[0:TASKS-1];
        end
    endtask

    task automatic random_run(int items);
        int sent;
        int n, kind, max_delta;
        logic [31:0] interval;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
            kind = $urandom_range(19);
            if (kind == 0) begin
                interval = 32'd0;
                max_delta = 100;
            end else if (kind < 4) begin
                interval = $urandom();
                max_delta = -1;
            end else begin
                interval = $urandom_range(1, 100000);
                max_delta = int'(interval) + int'(interval) / 4;
            end
            send_snapshot(n, interval, (max_delta < 0) ? 32'h7FFF_FFFF : max_delta);
            sent += n;
        end
    endtask

    task automatic test_pressure;
        hold_go <= 1'b1;
        send_snapshot(12, 32'd1000, 1200);
        send_snapshot(40, 32'd1000, 1200);
    endtask

    initial begin
        base_cnt = 0;
        snap_cnt = 0;
        top_n_reg = ntr_pkg::TOP_N_RST;
        min_pct_reg = ntr_pkg::MIN_PCT_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_baseline_seed();
        test_extremes();
        test_registers();
        test_overflow();

        write_reg(ntr_pkg::CFG_TOP_N, 32'd10);
        write_reg(ntr_pkg::CFG_MIN_PCT, 32'd2);
        send_idle_pct = 9;
        recv_idle_pct = 81;
        random_run(12);
        write_reg(ntr_pkg::CFG_TOP_N, 32'd16);
        write_reg(ntr_pkg::CFG_MIN_PCT, 32'd0);
        send_idle_pct = 81;
        recv_idle_pct = 9;
        random_run(12);
        write_reg(ntr_pkg::CFG_TOP_N, 32'd4);
        write_reg(ntr_pkg::CFG_MIN_PCT, 32'd10);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_pressure();
        random_run(12);

        i_valid <= 1'b0;
        while (ranked_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* sim.f */
sv/ntr_pkg.sv
sv/ntr_pct.sv
sv/ntr_core.sv
sv/task_runtime_top_n_ranker.sv
sv/ntr_checker.sv
sim/tb.sv
